>>> sv/scsad_pkg.sv
// ----------------------------------------------------------------------------
// Stereo SAD matching cost package
// Shared constants, item types and the per-pixel absolute-difference cost.
// ----------------------------------------------------------------------------
package scsad_pkg;

  localparam int NDISP     = 4;                 // disparities 0 .. NDISP-1
  localparam int WIN_DEPTH = NDISP - 1;         // pixel pairs held per row
  localparam int WIDX_W    = $clog2(WIN_DEPTH);
  localparam int CNT_W     = $clog2(NDISP);
  localparam int COL_W     = 12;
  localparam int WIDTH_W   = 13;
  localparam int MAX_WIDTH = 4096;
  localparam int COST_W    = 10;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);

  // register index, taken from the word address
  localparam logic REG_IMAGE_WIDTH = 1'b0;

  typedef logic [COST_W-1:0] cost_t;

  typedef struct packed {
    logic [7:0] left_red;
    logic [7:0] left_green;
    logic [7:0] left_blue;
    logic [7:0] right_red;
    logic [7:0] right_green;
    logic [7:0] right_blue;
  } scsad_in_t;

  typedef struct packed {
    cost_t cost_disp0;
    cost_t cost_disp1;
    cost_t cost_disp2;
    cost_t cost_disp3;
    logic  last_of_run;
  } scsad_out_t;

  // pairs[0] is the pixel whose result goes out next; pairs[1..lim] follow it
  typedef struct packed {
    scsad_in_t [NDISP-1:0] pairs;
    logic [CNT_W-1:0]      lim;
    logic [CNT_W-1:0]      rem;
  } scsad_job_t;

  typedef struct packed {
    logic             row_end;
    logic [COL_W-1:0] col;
  } scsad_stat_t;

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] res;
    res = (a > b) ? (a - b) : (b - a);
    return res;
  endfunction

  // right half of pixel r against left half of pixel l
  function automatic cost_t pair_cost(input scsad_in_t r, input scsad_in_t l);
    cost_t sum;
    sum = COST_W'(absdiff8(r.right_red, l.left_red))
        + COST_W'(absdiff8(r.right_green, l.left_green))
        + COST_W'(absdiff8(r.right_blue, l.left_blue));
    return sum;
  endfunction

endpackage

>>> sv/scsad_window.sv
// ----------------------------------------------------------------------------
// Stereo SAD pixel window
// Holds the recent pixel pairs of the row and the column count, and forms the
// run of pending pixels that each accepted item releases.
// ----------------------------------------------------------------------------
module scsad_window
  import scsad_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  scsad_in_t           in_data,
  input  logic [WIDTH_W-1:0]  image_width,
  output logic                new_job,
  output scsad_job_t          job,
  output scsad_stat_t         stat
);

  scsad_in_t        win_r [WIN_DEPTH];
  scsad_in_t        win_nxt [WIN_DEPTH];
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [COL_W-1:0] last_col;
  logic [CNT_W-1:0] n;
  logic             row_end;

  // last column of the row: zero acts as one, beyond the maximum is clipped
  always_comb begin
    if (image_width == '0) begin
      last_col = '0;
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(image_width - WIDTH_W'(1));
    end
  end

  assign row_end = (col_r >= last_col);
  assign n       = (col_r < COL_W'(WIN_DEPTH)) ? col_r[CNT_W-1:0] : CNT_W'(WIN_DEPTH);

  // oldest pending pixel first, current item at place n
  always_comb begin
    int idx;
    for (int i = 0; i < NDISP; i++) begin
      idx = int'(n) - 1 - i;
      if (i < int'(n)) begin
        job.pairs[i] = win_r[WIDX_W'(idx)];
      end else begin
        job.pairs[i] = in_data;
      end
    end
    job.lim = n;
    job.rem = row_end ? n : '0;
  end

  assign new_job = row_end || (n == CNT_W'(WIN_DEPTH));

  always_comb begin
    if (row_end) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_nxt[i] = '0;
      end
      col_nxt = '0;
    end else begin
      win_nxt[0] = in_data;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_nxt[i] = win_r[i-1];
      end
      col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (in_fire) begin
      col_r <= col_nxt;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  assign stat.row_end = row_end;
  assign stat.col     = col_r;

endmodule

>>> sv/scsad_cost.sv
// ----------------------------------------------------------------------------
// Stereo SAD cost sequencer
// Holds one run of pending pixels, computes one result item per cycle from
// the head of the run unless the output stalls, and drives the result register.
// ----------------------------------------------------------------------------
module scsad_cost
  import scsad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  scsad_job_t  job_in,
  output logic        take,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_ready,
  output scsad_out_t  out_data
);

  logic       job_valid_r;
  scsad_job_t job_r;
  scsad_job_t job_nxt;
  logic       emit;
  logic       run_done;
  cost_t      costs [NDISP];
  scsad_out_t res;
  logic       out_valid_r;
  scsad_out_t out_data_r;

  assign emit     = job_valid_r && (!out_valid_r || out_ready);
  assign run_done = emit && (job_r.rem == '0);
  assign take     = !job_valid_r || run_done;
  assign busy     = job_valid_r;

  // disparities past the end of the row cost zero
  always_comb begin
    for (int d = 0; d < NDISP; d++) begin
      if (d <= int'(job_r.lim)) begin
        costs[d] = pair_cost(job_r.pairs[0], job_r.pairs[d]);
      end else begin
        costs[d] = '0;
      end
    end
    res.cost_disp0  = costs[0];
    res.cost_disp1  = costs[1];
    res.cost_disp2  = costs[2];
    res.cost_disp3  = costs[3];
    res.last_of_run = (job_r.rem == '0);
  end

  // advance the run by one pixel
  always_comb begin
    job_nxt = job_r;
    for (int i = 0; i < NDISP - 1; i++) begin
      job_nxt.pairs[i] = job_r.pairs[i+1];
    end
    job_nxt.lim = job_r.lim - CNT_W'(1);
    job_nxt.rem = job_r.rem - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (load) begin
      job_valid_r <= 1'b1;
    end else if (run_done) begin
      job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_in;
    end else if (emit) begin
      job_r <= job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/stereo_sad_matching_cost_core.sv
// ----------------------------------------------------------------------------
// Stereo SAD matching cost core
// Streams paired left/right RGB pixels and delivers per-disparity SAD costs.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock and gives one result item per clock in a
// steady row while the output is not stalled: the costs of a pixel leave three
// items after it arrives, through the run register of the cost sequencer and
// then the result register. The item that ends a row releases every pixel
// still pending, so it occupies the cost sequencer for up to four result
// items and the input waits for that run to drain.
// Each result is formed by one cost unit that works on the head of the held
// run, one result per cycle unless the output stalls. The row width sits in
// the register at byte address 0; the user must write it only while the core is idle (not enforced).
module stereo_sad_matching_cost_core
  import scsad_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scsad_in_t         in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output scsad_out_t        out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [WIDTH_W-1:0] image_width_r;
  logic               cfg_wr;
  logic               in_fire;
  logic               new_job;
  scsad_job_t         job;
  scsad_stat_t        stat;
  logic               take;
  logic               busy;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= WIDTH_RESET;
    end else if (cfg_wr && (cfg_paddr[ADDR_W-1] == REG_IMAGE_WIDTH)) begin
      image_width_r <= cfg_pwdata[WIDTH_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[ADDR_W-1] == REG_IMAGE_WIDTH)
                    ? DATA_W'(image_width_r) : '0;

  assign in_ready = take;
  assign in_fire  = in_valid && in_ready;

  scsad_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_data     (in_data),
    .image_width (image_width_r),
    .new_job     (new_job),
    .job         (job),
    .stat        (stat)
  );

  scsad_cost u_cost (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && new_job),
    .job_in    (job),
    .take      (take),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a row-ending item returns the column count to zero
  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && stat.row_end) |=> (stat.col == '0))
    else $error("column count not cleared after row end");

  // results of one run leave back to back
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_of_run) |=> out_valid)
    else $error("gap inside a run of result items");

  // input only stalls behind a run still in the sequencer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> busy)
    else $error("input stalled with no run pending");

endmodule

>>> test/tb_stereo_sad_matching_cost_core.sv
// ----------------------------------------------------------------------------
// Stereo SAD matching cost core testbench
// Streams pixel pairs through the core under several row widths. It predicts
// each item's disparity costs and row-end flush, and compares every result
// item in order while both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_stereo_sad_matching_cost_core;
  import scsad_pkg::*;

  localparam int                SETTLE_CYCLES = 8;
  localparam int                RANDOM_ITEMS  = 120;
  localparam logic [ADDR_W-1:0] WIDTH_ADDR    = ADDR_W'(4 * REG_IMAGE_WIDTH);

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  scsad_in_t         in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  scsad_out_t        out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  // model state: pixel pairs of the current row, newest first
  scsad_in_t          pix_hist [WIN_DEPTH];
  int unsigned        next_col;
  logic [WIDTH_W-1:0] row_width;
  scsad_out_t         pending_costs [$];

  int err_cnt    = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int ready_hold = 0;

  stereo_sad_matching_cost_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // mostly short, now and then long
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 2);
  endfunction

  function automatic cost_t rgb_sad(input scsad_in_t r, input scsad_in_t l);
    int dr, dg, db;
    dr = int'(r.right_red) - int'(l.left_red);
    dg = int'(r.right_green) - int'(l.left_green);
    db = int'(r.right_blue) - int'(l.left_blue);
    return cost_t'((dr < 0 ? -dr : dr) + (dg < 0 ? -dg : dg) + (db < 0 ? -db : db));
  endfunction

  // costs of run[j]; disparities reaching past run[last] lie off the row
  function automatic scsad_out_t cost_item(input scsad_in_t run [NDISP], input int j,
                                           input int last);
    cost_t      c [NDISP];
    scsad_out_t res;
    for (int d = 0; d < NDISP; d++)
      c[d] = (j + d <= last) ? rgb_sad(run[j], run[j + d]) : cost_t'(0);
    res.cost_disp0  = c[0];
    res.cost_disp1  = c[1];
    res.cost_disp2  = c[2];
    res.cost_disp3  = c[3];
    res.last_of_run = 1'b0;
    return res;
  endfunction

  task automatic predict_costs(input scsad_in_t px);
    scsad_in_t  run [NDISP];
    scsad_out_t batch [$];
    int         eff_w, n, first;
    bit         row_end;
    eff_w = (row_width == 0) ? 1 : (row_width > MAX_WIDTH ? MAX_WIDTH : int'(row_width));
    n = (next_col < WIN_DEPTH) ? int'(next_col) : WIN_DEPTH;
    for (int j = 0; j < NDISP; j++)
      run[j] = '0;
    for (int j = 0; j < n; j++)
      run[j] = pix_hist[n - 1 - j];
    run[n] = px;
    row_end = (next_col >= eff_w - 1);
    first = 0;
    if (n == WIN_DEPTH) begin
      batch.push_back(cost_item(run, 0, n));
      first = 1;
    end
    if (row_end) begin
      for (int j = first; j <= n; j++)
        batch.push_back(cost_item(run, j, n));
    end
    if (batch.size() > 0)
      batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[i])
      pending_costs.push_back(batch[i]);
    if (row_end) begin
      for (int j = 0; j < WIN_DEPTH; j++)
        pix_hist[j] = '0;
      next_col = 0;
    end else begin
      for (int j = WIN_DEPTH - 1; j > 0; j--)
        pix_hist[j] = pix_hist[j - 1];
      pix_hist[0] = px;
      next_col++;
    end
  endtask

  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // result side: random back-pressure
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      ready_hold = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    scsad_out_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pending_costs.size() == 0) begin
        $error("result item with nothing expected: %p", out_data);
        err_cnt++;
      end else begin
        due = pending_costs.pop_front();
        check_field("cost_disp0", int'(due.cost_disp0), int'(out_data.cost_disp0));
        check_field("cost_disp1", int'(due.cost_disp1), int'(out_data.cost_disp1));
        check_field("cost_disp2", int'(due.cost_disp2), int'(out_data.cost_disp2));
        check_field("cost_disp3", int'(due.cost_disp3), int'(out_data.cost_disp3));
        check_field("last_of_run", int'(due.last_of_run), int'(out_data.last_of_run));
      end
    end
  end

  // hold valid and payload until the item is taken
  task automatic send_pixel(input scsad_in_t px);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    predict_costs(px);
  endtask

  function automatic scsad_in_t rand_pixel();
    logic [47:0] bits;
    bit          rails;
    rails = ($urandom_range(0, 3) == 0);
    for (int b = 0; b < 6; b++)
      bits[8*b +: 8] = rails ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom());
    return scsad_in_t'(bits);
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the width, then read it back
  task automatic set_row_width(input logic [WIDTH_W-1:0] value);
    logic [DATA_W-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= WIDTH_ADDR;
    cfg_pwdata  <= DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    row_width = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_field("image_width", int'(value), int'(rd));
  endtask

  // reset width: steady output from the fourth column, row left open
  task automatic test_reset_width();
    send_pixel(scsad_in_t'(48'h0));
    send_pixel(scsad_in_t'({24'hFFFFFF, 24'hFFFFFF}));
    send_pixel(scsad_in_t'({24'hFFFFFF, 24'h000000}));
    send_pixel(scsad_in_t'({24'h000000, 24'hFFFFFF}));
    send_pixel(scsad_in_t'({24'hAA55AA, 24'h55AA55}));
    send_pixel(scsad_in_t'({24'h55AA55, 24'hAA55AA}));
    wait_idle();
    set_row_width(WIDTH_RESET);
  endtask

  // width dropped below the open column: next item flushes the whole window
  task automatic test_width_drop_mid_row();
    set_row_width(WIDTH_W'(2));
    send_pixel(scsad_in_t'({24'h000000, 24'hFFFFFF}));
    send_pixel(scsad_in_t'({24'h123456, 24'hFEDCBA}));
    send_pixel(scsad_in_t'({24'hFFFFFF, 24'h000000}));
    send_pixel(scsad_in_t'({24'h00FF00, 24'hFF00FF}));
    wait_idle();
  endtask

  // zero acts as one; every item is its own row
  task automatic test_unit_width();
    set_row_width(WIDTH_W'(0));
    send_pixel(scsad_in_t'({24'hFFFFFF, 24'h000000}));
    send_pixel(scsad_in_t'({24'h808080, 24'h7F7F7F}));
    send_pixel(scsad_in_t'(48'h0));
    wait_idle();
    set_row_width(WIDTH_W'(1));
    send_pixel(scsad_in_t'({24'h000000, 24'hFFFFFF}));
    send_pixel(scsad_in_t'({24'h0F0F0F, 24'hF0F0F0}));
    wait_idle();
  endtask

  // widest register value and the maximum row keep the row open
  task automatic test_width_clamp();
    set_row_width({WIDTH_W{1'b1}});
    repeat (5) send_pixel(rand_pixel());
    wait_idle();
    set_row_width(WIDTH_W'(MAX_WIDTH));
    repeat (3) send_pixel(rand_pixel());
    wait_idle();
  endtask

  task automatic test_random_rows();
    int sent, burst, pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        set_row_width(WIDTH_W'(0));
      else if (pick == 1)
        set_row_width(WIDTH_W'($urandom_range(MAX_WIDTH, 8191)));
      else if (pick == 2)
        set_row_width(WIDTH_RESET);
      else
        set_row_width(WIDTH_W'($urandom_range(1, 9)));
      gap_pct   = $urandom_range(0, 2) == 0 ? 0 : 30;
      stall_pct = $urandom_range(0, 2) == 0 ? 0 : 30;
      burst = $urandom_range(1, 24);
      repeat (burst) send_pixel(rand_pixel());
      sent += burst;
      wait_idle();
    end
  endtask

  initial begin
    for (int j = 0; j < WIN_DEPTH; j++)
      pix_hist[j] = '0;
    next_col  = 0;
    row_width = WIDTH_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct   = 30;
    stall_pct = 30;
    test_reset_width();
    test_width_drop_mid_row();
    test_unit_width();
    test_width_clamp();
    test_random_rows();
    wait_idle();
    if (err_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
sv/scsad_pkg.sv
sv/scsad_window.sv
sv/scsad_cost.sv
sv/stereo_sad_matching_cost_core.sv
test/tb_stereo_sad_matching_cost_core.sv
